FILE: rtl/sst_pkg.sv
package sst_pkg;

   localparam int CMD_W    = 4;
   localparam int KEY_W    = 32;
   localparam int INDEX_W  = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_ADD        = 4'd0;
   localparam cmd_type CMD_REMOVE     = 4'd1;
   localparam cmd_type CMD_CONTAINS   = 4'd2;
   localparam cmd_type CMD_POP_MAX    = 4'd3;
   localparam cmd_type CMD_SHIFT_MIN  = 4'd4;
   localparam cmd_type CMD_READ_MAX   = 4'd5;
   localparam cmd_type CMD_READ_MIN   = 4'd6;
   localparam cmd_type CMD_READ_INDEX = 4'd7;
   localparam cmd_type CMD_CLEAR      = 4'd8;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_FULL  = 2'd3;

endpackage

FILE: rtl/sst_key_ram.sv
module sst_key_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sorted_set_table_unit.sv
// channel   direction  ports                                        handshake
// req       in         req_command, req_key, req_index              req_valid / req_stall
// rsp       out        rsp_hit, rsp_value, rsp_status, rsp_count    rsp_valid / rsp_stall
//
// one command at a time; req_stall is high from the accepting edge until the result transfers
// lookups: a binary search, each halving step a look state then a compare state on the single
// ram read port; add and remove then move one key per cycle through the same ram
// reads of largest, smallest or by index go through one ram read state, then the result state
// synchronous reset empties the table at once; the key ram itself is not cleared
// a stalled result holds in the output registers until rsp_stall falls
module sorted_set_table_unit
   import sst_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [INDEX_W-1:0]  req_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOOK = 4'd1;
   localparam logic [3:0] S_CMP  = 4'd2;
   localparam logic [3:0] S_POST = 4'd3;
   localparam logic [3:0] S_UP   = 4'd4;
   localparam logic [3:0] S_PUT  = 4'd5;
   localparam logic [3:0] S_DN   = 4'd6;
   localparam logic [3:0] S_RD   = 4'd7;
   localparam logic [3:0] S_RESP = 4'd8;

   logic [3:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        src_ff, src_in;
   logic                 hit_ff, hit_in;
   logic [KEY_WIDTH-1:0] val_ff, val_in;
   status_type           status_ff, status_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   logic [CW-1:0]        mid_w;
   logic [AW-1:0]        last_addr;
   logic [63:0]          val_wide;
   logic [12:0]          count_wide;

   sst_key_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid_w     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_addr = AW'(count_ff - CW'(1));

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      src_in    = src_ff;
      hit_in    = hit_ff;
      val_in    = val_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = key_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               key_in    = KEY_WIDTH'(req_key);
               hit_in    = 1'b0;
               val_in    = '0;
               status_in = ST_OK;
               lo_in     = '0;
               hi_in     = count_ff;
               found_in  = 1'b0;
               state_in  = S_RESP;
               case (req_command)
                  CMD_ADD, CMD_REMOVE, CMD_CONTAINS: begin
                     state_in = S_LOOK;
                  end
                  CMD_POP_MAX, CMD_READ_MAX: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_addr;
                        state_in = S_RD;
                     end
                  end
                  CMD_SHIFT_MIN, CMD_READ_MIN: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_RD;
                     end
                  end
                  CMD_READ_INDEX: begin
                     if (13'(req_index) >= 13'(count_ff)) begin
                        status_in = ST_RANGE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_index);
                        state_in = S_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_LOOK: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(mid_w);
               mid_in   = AW'(mid_w);
               state_in = S_CMP;
            end else begin
               pos_in   = lo_ff;
               found_in = 1'b0;
               state_in = S_POST;
            end
         end
         S_CMP: begin
            state_in = S_LOOK;
            if (key_ff > rd_data) begin
               lo_in = CW'(mid_ff) + CW'(1);
            end else if (key_ff < rd_data) begin
               hi_in = CW'(mid_ff);
            end else begin
               found_in = 1'b1;
               pos_in   = CW'(mid_ff);
               state_in = S_POST;
            end
         end
         S_POST: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_CONTAINS: begin
                  hit_in = found_ff;
               end
               CMD_ADD: begin
                  if (!found_ff) begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (pos_ff == count_ff) begin
                        state_in = S_PUT;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = last_addr;
                        src_in   = last_addr;
                        state_in = S_UP;
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     hit_in = 1'b1;
                     if (pos_ff + CW'(1) == count_ff) begin
                        count_in = count_ff - CW'(1);
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(pos_ff + CW'(1));
                        src_in   = AW'(pos_ff + CW'(1));
                        state_in = S_DN;
                     end
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = src_ff + AW'(1);
            wr_data = rd_data;
            if (CW'(src_ff) == pos_ff) begin
               state_in = S_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff - AW'(1);
               src_in  = src_ff - AW'(1);
            end
         end
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(pos_ff);
            wr_data  = key_ff;
            count_in = count_ff + CW'(1);
            hit_in   = 1'b1;
            state_in = S_RESP;
         end
         S_DN: begin
            wr_en   = 1'b1;
            wr_addr = src_ff - AW'(1);
            wr_data = rd_data;
            if (CW'(src_ff) + CW'(1) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff + AW'(1);
               src_in  = src_ff + AW'(1);
            end
         end
         S_RD: begin
            val_in   = rd_data;
            state_in = S_RESP;
            case (cmd_ff)
               CMD_POP_MAX: begin
                  count_in = count_ff - CW'(1);
               end
               CMD_SHIFT_MIN: begin
                  if (count_ff == CW'(1)) begin
                     count_in = '0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(1);
                     src_in   = AW'(1);
                     state_in = S_DN;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      found_ff  <= found_in;
      src_ff    <= src_in;
      hit_ff    <= hit_in;
      val_ff    <= val_in;
      status_ff <= status_in;
   end

   assign val_wide   = 64'(val_ff);
   assign count_wide = 13'(count_ff);

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_hit    = hit_ff;
   assign rsp_value  = val_wide[VALUE_W-1:0];
   assign rsp_status = status_ff;
   assign rsp_count  = count_wide[COUNT_W-1:0];

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("key count beyond capacity");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search window outside held keys");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == ST_FULL) |-> (count_ff == CW'(CAPACITY)))
      else $error("full status below capacity");

   a_hit_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && hit_ff |-> (status_ff == ST_OK) && (val_ff == '0))
      else $error("hit together with error or value");

   a_add_grows_by_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the count by one");
`endif

endmodule
